// File: src/i2c_master_byte_engine_core_assert.svh
// ---------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Clocked concurrent checks, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define I2C_MBE_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2C_MBE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/i2c_mbe_pkg.sv
// ---------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, slot numbers and the transfer and state types.
// ---------------------------------------------------------------------------
`default_nettype none

package i2c_mbe_pkg;

  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;

  localparam logic [4:0] LAST_BIT_LOW_SLOT = 5'd15;
  localparam logic [4:0] ACK_HIGH_SLOT     = 5'd16;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  phase;
    logic [7:0]  shift;
    logic        clk_o;
    logic        dat_o;
    logic [15:0] wait_cnt;
    logic [7:0]  held;
    logic        miss;
  } eng_state_t;

endpackage

`default_nettype wire

// File: src/i2c_mbe_step.sv
// ---------------------------------------------------------------------------
// I2C master byte engine step logic
// Next engine state and result for one transfer, from the current state.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_mbe_step
  import i2c_mbe_pkg::*;
(
  input  eng_state_t  st,
  input  in_item_t    item,
  input  logic [15:0] ack_timeout,
  output eng_state_t  st_nxt,
  output out_item_t   res
);

  logic        is_cmd;
  logic        fin;
  logic        hold;
  logic        done;
  logic        rej;
  logic [15:0] wait_inc;

  assign is_cmd   = item.operation inside {[CMD_START:CMD_ACK]};
  assign wait_inc = st.wait_cnt + {15'd0, (st.wait_cnt != WAIT_MAX)};

  always_comb begin
    st_nxt = st;
    fin    = 1'b0;
    hold   = 1'b0;
    done   = 1'b0;
    rej    = 1'b0;
    if (st.cmd == CMD_IDLE) begin
      if (is_cmd) begin
        st_nxt.cmd      = item.operation;
        st_nxt.phase    = 5'd0;
        st_nxt.wait_cnt = 16'd0;
        st_nxt.miss     = 1'b0;
        st_nxt.clk_o    = 1'b1;
        case (item.operation)
          CMD_START: st_nxt.dat_o = 1'b1;
          CMD_STOP:  st_nxt.dat_o = 1'b0;
          CMD_WRITE: begin
            st_nxt.shift = item.data_byte;
            st_nxt.dat_o = item.data_byte[7];
          end
          CMD_READ: begin
            st_nxt.shift = 8'd0;
            st_nxt.dat_o = 1'b1;
          end
          default:   st_nxt.dat_o = item.ack_level;
        endcase
      end
    end else if (is_cmd) begin
      rej = 1'b1;
    end else begin
      case (st.cmd)
        CMD_START: begin
          if (st.phase == 5'd0) begin
            st_nxt.dat_o = 1'b0;
          end else if (st.phase == 5'd1) begin
            st_nxt.clk_o = 1'b0;
          end else begin
            fin = 1'b1;
          end
        end
        CMD_STOP: begin
          if (st.phase == 5'd0) begin
            st_nxt.dat_o = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        CMD_ACK: begin
          if (st.phase == 5'd0) begin
            st_nxt.clk_o = 1'b0;
          end else begin
            fin = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (st.phase < ACK_HIGH_SLOT) begin
            if (!st.phase[0]) begin
              st_nxt.clk_o = 1'b0;
            end else if (st.phase == LAST_BIT_LOW_SLOT) begin
              st_nxt.dat_o    = 1'b1;
              st_nxt.clk_o    = 1'b1;
              st_nxt.wait_cnt = 16'd0;
            end else begin
              st_nxt.shift = {st.shift[6:0], 1'b0};
              st_nxt.dat_o = st.shift[6];
              st_nxt.clk_o = 1'b1;
            end
          end else if (st.phase == ACK_HIGH_SLOT) begin
            if (!item.sda_in) begin
              st_nxt.clk_o = 1'b0;
            end else begin
              st_nxt.wait_cnt = wait_inc;
              if ((ack_timeout != 16'd0) && (wait_inc >= ack_timeout)) begin
                st_nxt.miss  = 1'b1;
                st_nxt.clk_o = 1'b0;
              end else begin
                hold = 1'b1;
              end
            end
          end else begin
            fin = 1'b1;
          end
        end
        CMD_READ: begin
          if (!st.phase[0]) begin
            st_nxt.shift = {st.shift[6:0], item.sda_in};
            st_nxt.clk_o = 1'b0;
          end else if (st.phase >= LAST_BIT_LOW_SLOT) begin
            st_nxt.held = st.shift;
            fin = 1'b1;
          end else begin
            st_nxt.clk_o = 1'b1;
          end
        end
        default: hold = 1'b1;
      endcase
      if (fin) begin
        st_nxt.cmd   = CMD_IDLE;
        st_nxt.phase = 5'd0;
        done         = 1'b1;
      end else if (!hold) begin
        st_nxt.phase = st.phase + 5'd1;
      end
    end
  end

  always_comb begin
    res.scl_level   = st_nxt.clk_o;
    res.sda_release = st_nxt.dat_o;
    res.busy_res    = (st_nxt.cmd != CMD_IDLE);
    res.done_res    = done;
    res.read_data   = st_nxt.held;
    res.ack_missing = st_nxt.miss;
    res.rejected    = rej;
  end

endmodule

`default_nettype wire

// File: src/i2c_master_byte_engine_core.sv
// ---------------------------------------------------------------------------
// I2C master byte engine core
// Bit-level I2C master: one transfer in, one line-level result out.
//
//   channel  ports                      content
//   in       in_valid/in_ready/in_data  command or tick with sampled SDA
//   out      out_valid/out_ready/out_data  line levels and status
//   cfg      cfg_we/cfg_wdata           ack timeout in ticks
//
// One transfer per cycle while out_ready holds; each passes the input
// register, the single step of the engine state, then the result register.
// While a result waits, the input register takes one more transfer.
// rst_n (synchronous) releases both lines and clears the engine.
// A stalled out_ready backs up through the input register to in_ready.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_core
  import i2c_mbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        in_valid_r;
  in_item_t    in_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [15:0] ack_timeout_r;
  eng_state_t  st_r;
  eng_state_t  st_nxt;
  out_item_t   res;
  logic        step;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  i2c_mbe_step u_step (
    .st          (st_r),
    .item        (in_data_r),
    .ack_timeout (ack_timeout_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= 16'd0;
    end else if (cfg_we) begin
      ack_timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cmd      <= CMD_IDLE;
      st_r.phase    <= 5'd0;
      st_r.shift    <= 8'd0;
      st_r.clk_o    <= 1'b1;
      st_r.dat_o    <= 1'b1;
      st_r.wait_cnt <= 16'd0;
      st_r.held     <= 8'd0;
      st_r.miss     <= 1'b0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: src/i2c_mbe_checker.sv
// ---------------------------------------------------------------------------
// I2C master byte engine port checker
// Watches the top-level ports and flags result sequences that cannot occur.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_core_assert.svh"

module i2c_mbe_checker
  import i2c_mbe_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_item_t   out_data
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `I2C_MBE_CHECK_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result dropped")
  `I2C_MBE_CHECK_IMPL(a_rej_busy, out_valid && out_data.rejected, out_data.busy_res, "reject idle")
  `I2C_MBE_CHECK_IMPL(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res, "done busy")
  `I2C_MBE_CHECK_IMPL(a_miss_scl, out_valid && out_data.ack_missing, !out_data.scl_level, "scl high")

endmodule

bind i2c_master_byte_engine_core i2c_mbe_checker u_i2c_mbe_checker (.*);

`default_nettype wire
